// ===== rtl/core/xon_xoff_receive_pacing_buffer_assert.svh =====
// Assertion macros shared by the pacing buffer RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef XON_XOFF_RECEIVE_PACING_BUFFER_ASSERT_SVH
`define XON_XOFF_RECEIVE_PACING_BUFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define XXRPB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define XXRPB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/xxrpb_pkg.sv =====
package xxrpb_pkg;

	// Ring buffer geometry
	localparam int BUF_DEPTH = 256;
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	localparam int OCC_W     = $clog2(BUF_DEPTH + 1);
	localparam int CHAR_W    = 8;
	localparam int CFG_IDX_W = 1;

	// Register reset values
	localparam logic [CHAR_W-1:0] RESUME_CHAR_RST = 8'd17;
	localparam logic [CHAR_W-1:0] PAUSE_CHAR_RST  = 8'd19;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RESUME_CHAR = 1'b0,
		CFG_PAUSE_CHAR  = 1'b1
	} cfg_idx_t;

	// Item operation codes
	localparam logic OP_RX   = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Result flags carried through the read stage
	typedef struct packed {
		logic pop;
		logic pending;
		logic tx_allowed;
		logic overflow;
	} res_t;

	// Ring index advance with wrap at the last entry
	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(BUF_DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

endpackage

// ===== rtl/core/xxrpb_ram.sv =====
module xxrpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/xon_xoff_receive_pacing_buffer.sv =====
// XON/XOFF receive pacing buffer.
// Input channel (in_valid/in_ready): op = OP_RX carries a received byte with
// its parity flag; op = OP_READ is a host read that pops the oldest byte.
// Output channel (out_valid/out_ready): exactly one result item per input
// item, in order: popped byte and data_valid, pending, tx_allowed, overflow.
// Configuration port: cfg_we/cfg_index/cfg_data write resume (index 0) and
// pause (index 1) characters; write only while no item is in flight.
// A result passes the read stage (the synchronous buffer read) and then the
// output register before it appears.
// Throughput: one item per cycle unless the receiver stalls; the buffer
// control state updates at acceptance and the buffer RAM (one write port,
// one read port) takes at most one access per item.
// Reset: indices, occupancy and paused state clear, characters return to
// 17 and 19; buffer contents are not cleared and no clearing pass runs.
// When the receiver stalls, the output register holds its item, the read
// stage holds behind it, and in_ready drops until space frees up.
module xon_xoff_receive_pacing_buffer
	import xxrpb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [CHAR_W-1:0]    rx_byte,
	input  logic                 parity_bad,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHAR_W-1:0]    data_byte,
	output logic                 data_valid,
	output logic                 pending,
	output logic                 tx_allowed,
	output logic                 overflow,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CHAR_W-1:0]    cfg_data
);

	`include "xon_xoff_receive_pacing_buffer_assert.svh"

	logic [CHAR_W-1:0] resume_char_q;
	logic [CHAR_W-1:0] pause_char_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  wr_idx_q;
	logic [OCC_W-1:0]  occ_q;
	logic              paused_q;

	logic              valid_s1;
	res_t              res_s1;
	logic [CHAR_W-1:0] ram_rdata;

	logic              accept;
	logic              s1_adv;
	logic              is_full;
	logic              is_empty;
	logic              hit_pause;
	logic              hit_resume;
	logic              store;
	logic              push_ok;
	logic              pop_ok;
	logic              ovf;
	logic              paused_d;
	logic [OCC_W-1:0]  occ_d;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resume_char_q <= RESUME_CHAR_RST;
			pause_char_q  <= PAUSE_CHAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RESUME_CHAR: resume_char_q <= cfg_data;
				CFG_PAUSE_CHAR:  pause_char_q  <= cfg_data;
			endcase
		end
	end

	// Handshake: read stage moves on when the output register is free
	assign s1_adv   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign accept   = in_valid && in_ready;

	// Item decode
	assign is_full    = (occ_q == OCC_W'(BUF_DEPTH));
	assign is_empty   = (occ_q == '0);
	assign hit_pause  = !paused_q && (rx_byte == pause_char_q) && !parity_bad;
	assign hit_resume = paused_q && (rx_byte == resume_char_q);
	assign store      = (op == OP_RX) && !hit_pause && !hit_resume;
	assign push_ok    = store && !is_full;
	assign ovf        = store && is_full;
	assign pop_ok     = (op == OP_READ) && !is_empty;

	// Next paused state and occupancy
	always_comb begin
		paused_d = paused_q;
		occ_d    = occ_q;
		if (op == OP_RX) begin
			if (hit_pause) begin
				paused_d = 1'b1;
			end else if (hit_resume && !parity_bad) begin
				paused_d = 1'b0;
			end
		end
		if (push_ok) begin
			occ_d = occ_q + OCC_W'(1);
		end else if (pop_ok) begin
			occ_d = occ_q - OCC_W'(1);
		end
	end

	// Buffer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			occ_q    <= '0;
			paused_q <= 1'b0;
		end else if (accept) begin
			if (push_ok) begin
				wr_idx_q <= idx_next(wr_idx_q);
			end
			if (pop_ok) begin
				rd_idx_q <= idx_next(rd_idx_q);
			end
			occ_q    <= occ_d;
			paused_q <= paused_d;
		end
	end

	// Hold buffer
	xxrpb_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(BUF_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept && push_ok),
		.waddr(wr_idx_q),
		.wdata(rx_byte),
		.re   (accept && pop_ok),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	// Read stage: waits for the buffer data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.pop        <= pop_ok;
			res_s1.pending    <= (occ_d != '0);
			res_s1.tx_allowed <= !paused_d;
			res_s1.overflow   <= ovf;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			data_byte  <= res_s1.pop ? ram_rdata : '0;
			data_valid <= res_s1.pop;
			pending    <= res_s1.pending;
			tx_allowed <= res_s1.tx_allowed;
			overflow   <= res_s1.overflow;
		end
	end

	// Checks
	`XXRPB_ASSERT_IMP(a_occ_range, 1'b1, occ_q <= OCC_W'(BUF_DEPTH), "occupancy above depth")
	`XXRPB_ASSERT_IMP(a_stall_blocks, valid_s1 && out_valid && !out_ready, !in_ready, "accept while read stage stalled")
	`XXRPB_ASSERT_NXT(a_push_count, accept && push_ok, occ_q == $past(occ_q) + OCC_W'(1), "push did not count")
	`XXRPB_ASSERT_IMP(a_ovf_full, valid_s1 && res_s1.overflow, occ_q == OCC_W'(BUF_DEPTH), "overflow while not full")
	`XXRPB_ASSERT_IMP(a_empty_zero, out_valid && !data_valid, data_byte == '0, "nonzero byte without data")

endmodule
